[rtl/crop_and_zoom_2x_interpolate_core_defines.svh]
// Shared assertion macros for the crop-and-zoom core.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef CROP_AND_ZOOM_2X_INTERPOLATE_CORE_DEFINES_SVH
`define CROP_AND_ZOOM_2X_INTERPOLATE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CZI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CZI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/czi_pkg.sv]
package czi_pkg;

  // Default sizes of the source line and of the crop window.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SPAN_DEF  = 512;

  // Fixed field widths.
  localparam int PIX_W     = 8;
  localparam int POS_W     = 10;
  localparam int ROW_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_SLOTS = 4;

  // Rows beyond this one are ignored until the next frame start.
  localparam logic [ROW_W-1:0] LAST_ROW = 10'd1023;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_CROP_LEFT   = 2'd1,
    CFG_CROP_TOP    = 2'd2,
    CFG_WINDOW_SPAN = 2'd3
  } cfg_idx_t;

  // Result slots of one source pixel, in emission order.
  localparam logic [1:0] SLOT_DIAG = 2'd0;  // (2r-1, 2c-1)
  localparam logic [1:0] SLOT_VERT = 2'd1;  // (2r-1, 2c)
  localparam logic [1:0] SLOT_HORZ = 2'd2;  // (2r,   2c-1)
  localparam logic [1:0] SLOT_COPY = 2'd3;  // (2r,   2c)

  // A window pixel on its way from the front end to the result emitter.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [PIX_W-1:0] left;
    logic [POS_W-1:0] row2;
    logic [POS_W-1:0] col2;
    logic             has_up;
    logic             has_left;
  } czi_item_t;

  // Floor of the mean of two pixels.
  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W:1];
  endfunction

endpackage

[rtl/czi_ram.sv]
module czi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic                           re,
  input  logic [AW-1:0]                  addr,
  input  logic [WIDTH-1:0]               wdata,
  output logic [WIDTH-1:0]               rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read-first: a read and a write of one entry in the same
  // cycle return the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

[rtl/czi_front.sv]
module czi_front #(
  parameter int MAX_WIDTH = czi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SPAN  = czi_pkg::MAX_SPAN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [czi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [czi_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [czi_pkg::PIX_W-1:0]       in_pixel_value,
  input  logic                            in_frame_start,
  output logic                            item_valid,
  input  logic                            item_ready,
  output czi_pkg::czi_item_t              item,
  output logic [czi_pkg::PIX_W-1:0]       above
);
  import czi_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(MAX_SPAN + 1);
  localparam int AW    = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int XW0   = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int XW    = ((XW0 > SW) ? XW0 : SW) + 1;

  localparam logic [XW-1:0] W_MAX = XW'(MAX_WIDTH);
  localparam logic [XW-1:0] S_MAX = XW'(MAX_SPAN);
  localparam logic [XW-1:0] ONE   = XW'(1);

  logic [CFG_W-1:0] image_width_r;
  logic [POS_W-1:0] crop_left_r, crop_top_r, window_span_r;
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic             over_r, over_nxt, over_cur;
  logic [PIX_W-1:0] left_r;
  logic             item_valid_r;
  czi_item_t        item_r;

  logic [XW-1:0] w_ext, w_eff, n_ext, n_eff;
  logic [XW-1:0] col_ext, row_ext, col_off, row_off, col_plus;
  logic          in_win, accept, win_accept;
  logic [AW-1:0] lb_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= CFG_W'(1024);
      crop_left_r   <= '0;
      crop_top_r    <= '0;
      window_span_r <= POS_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH: image_width_r <= cfg_data;
        CFG_CROP_LEFT:   crop_left_r   <= cfg_data[POS_W-1:0];
        CFG_CROP_TOP:    crop_top_r    <= cfg_data[POS_W-1:0];
        CFG_WINDOW_SPAN: window_span_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width and span into their legal ranges.
  always_comb begin
    w_ext = XW'(image_width_r);
    n_ext = XW'(window_span_r);
    if (w_ext == '0) begin
      w_eff = ONE;
    end else if (w_ext > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = w_ext;
    end
    if (n_ext == '0) begin
      n_eff = ONE;
    end else if (n_ext > S_MAX) begin
      n_eff = S_MAX;
    end else begin
      n_eff = n_ext;
    end
  end

  // Position of the pixel on the input, and whether it falls in the window.
  always_comb begin
    col_cur  = in_frame_start ? '0 : col_r;
    row_cur  = in_frame_start ? '0 : row_r;
    over_cur = in_frame_start ? 1'b0 : over_r;
    col_ext  = XW'(col_cur);
    row_ext  = XW'(row_cur);
    col_off  = col_ext - XW'(crop_left_r);
    row_off  = row_ext - XW'(crop_top_r);
    in_win   = !over_cur &&
               (col_ext >= XW'(crop_left_r)) && (col_off < n_eff) &&
               (row_ext >= XW'(crop_top_r)) && (row_off < n_eff);
    lb_addr  = col_off[AW-1:0];
  end

  // Raster counter for the next pixel.
  always_comb begin
    col_plus = col_ext + ONE;
    col_nxt  = col_cur;
    row_nxt  = row_cur;
    over_nxt = over_cur;
    if (!over_cur) begin
      if (col_plus >= w_eff) begin
        col_nxt = '0;
        if (row_cur >= LAST_ROW) begin
          over_nxt = 1'b1;
        end else begin
          row_nxt = row_cur + ROW_W'(1);
        end
      end else begin
        col_nxt = col_plus[COL_W-1:0];
      end
    end
  end

  assign in_ready   = !item_valid_r || item_ready;
  assign accept     = in_valid && in_ready;
  assign win_accept = accept && in_win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      over_r       <= 1'b0;
      left_r       <= '0;
      item_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        over_r <= over_nxt;
      end
      if (win_accept) begin
        left_r       <= in_pixel_value;
        item_valid_r <= 1'b1;
      end else if (item_ready) begin
        item_valid_r <= 1'b0;
      end
    end
  end

  // Window pixel held for the emitter; the line buffer read lands alongside.
  always_ff @(posedge clk) begin
    if (win_accept) begin
      item_r.value    <= in_pixel_value;
      item_r.left     <= left_r;
      item_r.row2     <= {row_off[POS_W-2:0], 1'b0};
      item_r.col2     <= {col_off[POS_W-2:0], 1'b0};
      item_r.has_up   <= (row_off != '0);
      item_r.has_left <= (col_off != '0);
    end
  end

  // Line buffer: the previous window row, read and overwritten in one access.
  czi_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SPAN),
    .AW    (AW)
  ) u_line_buf (
    .clk   (clk),
    .we    (win_accept),
    .re    (win_accept),
    .addr  (lb_addr),
    .wdata (in_pixel_value),
    .rdata (above)
  );

  assign item_valid = item_valid_r;
  assign item       = item_r;
endmodule

[rtl/czi_emit.sv]
module czi_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  czi_pkg::czi_item_t          item,
  input  logic [czi_pkg::PIX_W-1:0]   above,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [czi_pkg::POS_W-1:0]   out_row,
  output logic [czi_pkg::POS_W-1:0]   out_col,
  output logic [czi_pkg::PIX_W-1:0]   out_value,
  output logic                        out_last_of_run
);
  import czi_pkg::*;

  logic [NUM_SLOTS-1:0] mask_r, mask_nxt;
  logic [PIX_W-1:0]     val_r [NUM_SLOTS];
  logic [POS_W-1:0]     row2_r, col2_r;
  logic [PIX_W-1:0]     ul_r;
  logic                 one_left, free, load;
  logic [1:0]           sel;
  logic [PIX_W-1:0]     low_mid, up_mid;

  // The run finishes when at most one result is pending and it is taken.
  assign one_left   = ((mask_r & (mask_r - NUM_SLOTS'(1))) == '0);
  assign free       = (mask_r == '0) || (one_left && out_ready);
  assign item_ready = free;
  assign load       = item_valid && free;

  assign low_mid = avg2(item.left, item.value);
  assign up_mid  = avg2(ul_r, above);

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt            = '0;
      mask_nxt[SLOT_DIAG] = item.has_up && item.has_left;
      mask_nxt[SLOT_VERT] = item.has_up;
      mask_nxt[SLOT_HORZ] = item.has_left;
      mask_nxt[SLOT_COPY] = 1'b1;
    end else if (out_valid && out_ready) begin
      mask_nxt = mask_r & (mask_r - NUM_SLOTS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      ul_r   <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (load) begin
        ul_r <= above;
      end
    end
  end

  // Result values of the whole run, computed when the pixel arrives.
  always_ff @(posedge clk) begin
    if (load) begin
      val_r[SLOT_DIAG] <= avg2(up_mid, low_mid);
      val_r[SLOT_VERT] <= avg2(above, item.value);
      val_r[SLOT_HORZ] <= low_mid;
      val_r[SLOT_COPY] <= item.value;
      row2_r           <= item.row2;
      col2_r           <= item.col2;
    end
  end

  // Lowest pending slot goes out first.
  always_comb begin
    if (mask_r[SLOT_DIAG]) begin
      sel = SLOT_DIAG;
    end else if (mask_r[SLOT_VERT]) begin
      sel = SLOT_VERT;
    end else if (mask_r[SLOT_HORZ]) begin
      sel = SLOT_HORZ;
    end else begin
      sel = SLOT_COPY;
    end
  end

  assign out_valid       = (mask_r != '0);
  assign out_last_of_run = one_left;
  assign out_value       = val_r[sel];
  assign out_row = (sel == SLOT_DIAG || sel == SLOT_VERT) ? row2_r - POS_W'(1) : row2_r;
  assign out_col = (sel == SLOT_DIAG || sel == SLOT_HORZ) ? col2_r - POS_W'(1) : col2_r;
endmodule

[rtl/crop_and_zoom_2x_interpolate_core.sv]
// Crop and 2x zoom of an 8-bit greyscale stream with linear interpolation.
// Source pixels enter in raster order on the in_ channel (valid/ready); a
// pixel with in_frame_start set restarts the position at row 0, column 0.
// Each pixel inside the configured window gives one to four zoomed pixels on
// the out_ channel, tagged with zoomed row and column; out_last_of_run marks
// the final one. Pixels outside the window are accepted but give no
// transaction. The first result of a pixel is shown after it passes the
// front-end item register and the emitter's result registers. The single
// result port sets the throughput: a window pixel occupies it until all its
// results, up to four, are taken, and the line buffer is read and written
// once per window pixel, so the next pixel is accepted while the current run
// drains. Registers on the cfg_ port are to be written by the user only while
// the block is idle; the block itself does not enforce this.
// Reset (rst_n low at a clock edge) restores the register defaults, clears the
// position and discards pending results; the line buffer is not cleared.
// When out_ready is low the current result holds and, after one buffered
// pixel, in_ready falls.
module crop_and_zoom_2x_interpolate_core #(
  parameter int MAX_WIDTH = czi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SPAN  = czi_pkg::MAX_SPAN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [czi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [czi_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [czi_pkg::PIX_W-1:0]       in_pixel_value,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [czi_pkg::POS_W-1:0]       out_row,
  output logic [czi_pkg::POS_W-1:0]       out_col,
  output logic [czi_pkg::PIX_W-1:0]       out_value,
  output logic                            out_last_of_run
);
  import czi_pkg::*;

  logic             item_valid, item_ready;
  czi_item_t        item;
  logic [PIX_W-1:0] above;

  // Position tracking, window test and line buffer.
  czi_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SPAN  (MAX_SPAN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .in_frame_start (in_frame_start),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .above          (above)
  );

  // Interpolation and serialisation of the results.
  czi_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .above           (above),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );
endmodule

[rtl/czi_checker.sv]
`include "crop_and_zoom_2x_interpolate_core_defines.svh"

module czi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [czi_pkg::POS_W-1:0]       out_row,
  input logic [czi_pkg::POS_W-1:0]       out_col,
  input logic [czi_pkg::PIX_W-1:0]       out_value,
  input logic                            out_last_of_run
);
  // A stalled result keeps its payload.
  `CZI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_row) && $stable(out_col) &&
                   $stable(out_value) && $stable(out_last_of_run),
                   "stalled result changed")

  // A run never stops before its last transaction.
  `CZI_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !out_last_of_run,
                   out_valid, "run ended before its last result")

  // The copied source pixel, at even row and column, is always last of its run.
  `CZI_ASSERT_NOW(a_last_is_copy, out_valid,
                  out_last_of_run == (!out_row[0] && !out_col[0]),
                  "last flag does not match an even position")
endmodule

bind crop_and_zoom_2x_interpolate_core czi_checker u_czi_checker (.*);

[dv/testbench.sv]
module testbench;
  import czi_pkg::*;

  // Run limits and pacing.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int IDLE_PAD       = 8;
  localparam int RANDOM_ITEMS   = 50;
  localparam int HOLD_OFF       = 300;
  localparam int MAX_PRINTED    = 100;

  // Receiver stall patterns.
  localparam int RX_FREE     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_MOSTLY   = 2;
  localparam int RX_PERIODIC = 3;

  // One zoomed pixel as it should appear on the result channel.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             is_last;
  } zoom_px_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel_value;
  logic              in_frame_start;
  logic              out_valid;
  logic              out_ready;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_col;
  logic [PIX_W-1:0]  out_value;
  logic              out_last_of_run;

  crop_and_zoom_2x_interpolate_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_value  (in_pixel_value),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Zoomed pixels still owed by the block, oldest first.
  zoom_px_t zoomed_q[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       live_items = 0;
  int       hold_cycles = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;

  // Shadow copy of the registers and of the block's position state.
  logic [CFG_W-1:0] img_width = 11'd1024;
  logic [POS_W-1:0] crop_left = '0;
  logic [ROW_W-1:0] crop_top = '0;
  logic [POS_W-1:0] win_span = 10'd1;
  int unsigned      src_col = 0;
  int unsigned      src_row = 0;
  int unsigned      left_px = 0;
  int unsigned      upper_left = 0;
  bit               rows_over = 1'b0;
  logic [PIX_W-1:0] line_buf [MAX_SPAN_DEF];

  initial begin
    for (int i = 0; i < MAX_SPAN_DEF; i++) line_buf[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("%s", msg);
    mismatches++;
  endtask

  function automatic void push_zoomed(input int unsigned row, input int unsigned col,
                                      input int unsigned val, input bit last_one);
    zoom_px_t px;
    px.row     = row[POS_W-1:0];
    px.col     = col[POS_W-1:0];
    px.value   = val[PIX_W-1:0];
    px.is_last = last_one;
    zoomed_q.push_back(px);
  endfunction

  // Works out the zoomed pixels that one source pixel releases and advances
  // the position. Returns 0 when the pixel falls past the last countable row.
  function automatic bit upscale_pixel(input int unsigned v, input bit start);
    int unsigned w;
    int unsigned n;
    int unsigned r;
    int unsigned c;
    int unsigned above;
    bit          taken;
    if (start) begin
      src_col   = 0;
      src_row   = 0;
      rows_over = 1'b0;
    end
    taken = !rows_over;
    w = img_width;
    n = win_span;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (n < 1) n = 1;
    if (n > MAX_SPAN_DEF) n = MAX_SPAN_DEF;

    if (!rows_over && src_col >= crop_left && src_col - crop_left < n &&
        src_row >= crop_top && src_row - crop_top < n) begin
      r = src_row - crop_top;
      c = src_col - crop_left;
      above = line_buf[c];
      if (r > 0) begin
        if (c > 0)
          push_zoomed(2*r - 1, 2*c - 1,
                      (((upper_left + above) >> 1) + ((left_px + v) >> 1)) >> 1, 1'b0);
        push_zoomed(2*r - 1, 2*c, (above + v) >> 1, 1'b0);
      end
      if (c > 0) push_zoomed(2*r, 2*c - 1, (left_px + v) >> 1, 1'b0);
      push_zoomed(2*r, 2*c, v, 1'b1);
      upper_left  = above;
      line_buf[c] = v[PIX_W-1:0];
      left_px     = v;
    end

    if (!rows_over) begin
      if (src_col + 1 >= w) begin
        src_col = 0;
        if (src_row >= LAST_ROW) rows_over = 1'b1;
        else src_row++;
      end else begin
        src_col++;
      end
    end
    return taken;
  endfunction

  // Offers one source pixel, in bursts with random gaps when gaps are enabled.
  task automatic send_pixel(input int unsigned value, input bit start);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid       <= 1'b1;
    in_pixel_value <= value[PIX_W-1:0];
    in_frame_start <= start;
    do @(posedge clk); while (!in_ready);
    if (upscale_pixel(value, start)) live_items++;
  endtask

  task automatic send_random_pixels(input int count, input bit start_frame);
    for (int i = 0; i < count; i++)
      send_pixel($urandom_range(0, 255), start_frame && i == 0);
  endtask

  // Stops offering and waits until every owed result has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (zoomed_q.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH: img_width = data;
      CFG_CROP_LEFT:   crop_left = data[POS_W-1:0];
      CFG_CROP_TOP:    crop_top  = data[ROW_W-1:0];
      default:         win_span  = data[POS_W-1:0];
    endcase
  endtask

  task automatic set_window(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] l,
                            input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] s);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_CROP_LEFT, l);
    write_reg(CFG_CROP_TOP, t);
    write_reg(CFG_WINDOW_SPAN, s);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Register defaults: a one-pixel window at the origin of a 1024-wide image.
  task automatic test_reset_defaults();
    send_pixel(8'hab, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hff, 1'b0);
    wait_idle();
  endtask

  // A 3x3 window with extreme values, so that every result slot is produced.
  task automatic test_interpolation_extremes();
    int unsigned pix [12];
    pix = '{255, 0, 255, 1, 0, 255, 254, 0, 255, 255, 0, 255};
    set_window(11'd4, 11'd0, 11'd0, 11'd3);
    for (int i = 0; i < 12; i++) send_pixel(pix[i], i == 0);
    wait_idle();
  endtask

  // A zero width acts as one column and a zero span as one pixel.
  task automatic test_register_clamping();
    set_window(11'd0, 11'd0, 11'd1, 11'd0);
    send_random_pixels(3, 1'b1);
    wait_idle();
  endtask

  // Oversized width and span clamp to their limits and still give a window.
  task automatic test_oversized_registers();
    set_window(11'd2047, 11'd2, 11'd0, 11'd1023);
    send_random_pixels(10, 1'b1);
    wait_idle();
  endtask

  // The window runs past the right edge of the image.
  task automatic test_window_past_edge();
    set_window(11'd5, 11'd3, 11'd0, 11'd4);
    send_random_pixels(20, 1'b1);
    wait_idle();
  endtask

  // The width shrinks below the current column in the middle of a row.
  task automatic test_width_change_mid_row();
    set_window(11'd8, 11'd0, 11'd2, 11'd3);
    send_random_pixels(11, 1'b1);
    wait_idle();
    set_window(11'd3, 11'd0, 11'd2, 11'd3);
    send_random_pixels(10, 1'b0);
    wait_idle();
  endtask

  // A new frame starts while the window is half done.
  task automatic test_restart_mid_window();
    set_window(11'd4, 11'd0, 11'd0, 11'd3);
    send_random_pixels(6, 1'b1);
    send_random_pixels(12, 1'b1);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while pixels keep coming.
  task automatic test_input_backpressure();
    set_window(11'd6, 11'd0, 11'd0, 11'd6);
    gaps_on = 1'b0;
    hold_cycles = HOLD_OFF;
    send_random_pixels(36, 1'b1);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // Random small windows, mostly whole frames, with some restarts and cut frames.
  task automatic test_random_frames();
    int          start_count;
    int          w;
    int          l;
    int          t;
    int          s;
    int          rows;
    int          npix;
    logic [CFG_W-1:0] l_data;
    logic [CFG_W-1:0] t_data;
    logic [CFG_W-1:0] s_data;
    start_count = live_items;
    while (live_items - start_count < RANDOM_ITEMS) begin
      w = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) w = 0;
      l = $urandom_range(0, 4);
      t = $urandom_range(0, 2);
      s = $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) s = 0;
      // The top bit of the data is unused by the 10-bit registers.
      l_data = CFG_W'(l) | (($urandom_range(0, 1) == 1) ? 11'h400 : 11'h000);
      t_data = CFG_W'(t) | (($urandom_range(0, 1) == 1) ? 11'h400 : 11'h000);
      s_data = CFG_W'(s) | (($urandom_range(0, 1) == 1) ? 11'h400 : 11'h000);
      set_window(CFG_W'(w), l_data, t_data, s_data);
      rows = t + ((s == 0) ? 1 : s) + $urandom_range(0, 1);
      npix = rows * ((w == 0) ? 1 : w);
      if ($urandom_range(0, 3) == 0) npix = $urandom_range(1, npix);
      gaps_on = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < npix; i++)
        send_pixel($urandom_range(0, 255), i == 0 || $urandom_range(0, 39) == 0);
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: changes its stall pattern at the end of each randomly sized
  // segment, and holds off completely when a test asks for it.
  initial begin : result_receiver
    int mode;
    int seg_left;
    int tick;
    mode = RX_FREE;
    seg_left = 0;
    tick = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles - 1) @(posedge clk);
        hold_cycles = 0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(RX_FREE, RX_PERIODIC);
          seg_left = $urandom_range(8, 64);
        end
        seg_left--;
        tick++;
        case (mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:   out_ready <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Each result transaction is compared with the oldest owed zoomed pixel.
  always @(posedge clk) begin : result_check
    zoom_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (zoomed_q.size() == 0) begin
        report_mismatch($sformatf("Unexpected transaction: row %0d col %0d value %0d",
                                  out_row, out_col, out_value));
      end else begin
        want = zoomed_q.pop_front();
        if (out_row !== want.row)
          report_mismatch($sformatf("out_row: got %0d, expected %0d", out_row, want.row));
        if (out_col !== want.col)
          report_mismatch($sformatf("out_col: got %0d, expected %0d (row %0d)",
                                    out_col, want.col, want.row));
        if (out_value !== want.value)
          report_mismatch($sformatf("out_value: got %0d, expected %0d (row %0d col %0d)",
                                    out_value, want.value, want.row, want.col));
        if (out_last_of_run !== want.is_last)
          report_mismatch($sformatf("out_last_of_run: got %0b, expected %0b (row %0d col %0d)",
                                    out_last_of_run, want.is_last, want.row, want.col));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_IMAGE_WIDTH;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_pixel_value <= '0;
    in_frame_start <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_interpolation_extremes();
    test_register_clamping();
    test_oversized_registers();
    test_window_past_edge();
    test_width_change_mid_row();
    test_restart_mid_window();
    test_input_backpressure();
    test_random_frames();

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && zoomed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
